// File: rtl/bcx_pkg.sv
// Package: opcodes, flag positions, result record and register map for the execute stage.
`timescale 1ns / 1ps
package bcx_pkg;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
        OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
        OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
        OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
        OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
        OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
        OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
        OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
        OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
        OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
        OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
        OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
        OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
        OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
    } t_op;

    localparam int FL_N = 7;
    localparam int FL_V = 6;
    localparam int FL_X = 5;
    localparam int FL_B = 4;
    localparam int FL_D = 3;
    localparam int FL_I = 2;
    localparam int FL_Z = 1;
    localparam int FL_C = 0;

    localparam logic [7:0]  SP_RESET     = 8'hFD;
    localparam logic [7:0]  STATUS_RESET = 8'h24;
    localparam logic [7:0]  STACK_PAGE   = 8'h01;
    localparam logic [7:0]  PUSH_BITS    = 8'h30;

    // register indexes on the config port
    localparam logic [0:0] REG_START = 1'b0;
    localparam logic [0:0] REG_BRK   = 1'b1;

    typedef struct packed {
        logic        has_write;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        last;
        logic [7:0]  acc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  stack_pointer;
        logic [7:0]  flags;
        logic [15:0] program_counter;
        logic [1:0]  branch_penalty;
    } t_result;

    typedef struct packed {
        logic [5:0]  opcode;
        logic        accumulator_mode;
        logic [7:0]  operand;
        logic [15:0] address;
        logic [23:0] stack_bytes;
    } t_instr;

    // architectural registers handed from the executor
    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  p;
        logic [15:0] pc;
    } t_arch;

endpackage

// File: rtl/bcx_if.sv
// Valid/ready stream interfaces for instruction and result items.
`timescale 1ns / 1ps
interface bcx_in_if import bcx_pkg::*; ();
    logic   valid;
    logic   ready;
    t_instr data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface bcx_out_if import bcx_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: rtl/eight_bit_cpu_execute_stage.sv
// Top level: config registers, executor and result sequencer of the execute stage.
// The first result of an accepted instruction is registered and shown in the cycle after it is accepted.
// Throughput: one instruction per cycle when it makes at most one write and the output is ready;
// BRK and JSR hold off new input until all their stack write items have drained.
// Reset (i_rst_n, synchronous, low): A=X=Y=0, SP=0xFD, P=0x24, PC=start address,
// config registers cleared; the result register empties.
`timescale 1ns / 1ps
module eight_bit_cpu_execute_stage import bcx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcx_in_if.sink      i_in,
    bcx_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] w_start, w_brk;
    t_arch       w_arch;
    logic [1:0]  w_nw, w_pen;
    logic [15:0] w_wa [3];
    logic [7:0]  w_wd [3];
    logic        w_fire;

    logic        r_valid;
    t_result     r_res;
    logic [1:0]  r_left;
    logic [15:0] r_wa [2];
    logic [7:0]  r_wd [2];
    logic        r_idx;

    bcx_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_start_address(w_start), .o_break_vector(w_brk)
    );

    // input accepted when the result stage frees on this edge
    assign i_in.ready = !r_valid || (o_out.ready && r_left == 2'd0);
    assign w_fire     = i_in.valid && i_in.ready;

    bcx_exec u_exec (
        .i_clk, .i_rst_n, .i_fire(w_fire), .i_instr(i_in.data),
        .i_start_address(w_start), .i_break_vector(w_brk),
        .o_arch(w_arch), .o_nw(w_nw), .o_wa(w_wa), .o_wd(w_wd), .o_pen(w_pen)
    );

    // result register and drain of pending stack writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
            r_idx   <= 1'b0;
        end else if (w_fire) begin
            r_valid                 <= 1'b1;
            r_res.has_write         <= (w_nw != 2'd0);
            r_res.write_address     <= w_wa[0];
            r_res.write_data        <= w_wd[0];
            r_res.last              <= (w_nw <= 2'd1);
            r_res.acc               <= w_arch.a;
            r_res.index_x           <= w_arch.x;
            r_res.index_y           <= w_arch.y;
            r_res.stack_pointer     <= w_arch.sp;
            r_res.flags             <= w_arch.p;
            r_res.program_counter   <= w_arch.pc;
            r_res.branch_penalty    <= w_pen;
            r_left                  <= (w_nw == 2'd0) ? 2'd0 : w_nw - 2'd1;
            r_wa[0] <= w_wa[1]; r_wa[1] <= w_wa[2];
            r_wd[0] <= w_wd[1]; r_wd[1] <= w_wd[2];
            r_idx   <= 1'b0;
        end else if (r_valid && o_out.ready) begin
            if (r_left == 2'd0) begin
                r_valid <= 1'b0;
            end else begin
                r_res.write_address <= r_wa[r_idx];
                r_res.write_data    <= r_wd[r_idx];
                r_res.last          <= (r_left == 2'd1);
                r_left              <= r_left - 2'd1;
                r_idx               <= r_idx + 1'b1;
            end
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_res;

    // last marks exactly the final item of an instruction
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res.last == (r_left == 2'd0)))
        else $error("last flag out of step with pending writes");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_left != 2'd0) |-> !i_in.ready)
        else $error("input taken while writes pending");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_left != 2'd0 |-> r_res.has_write)
        else $error("pending writes without a write item");
endmodule

// File: rtl/bcx_cfg.sv
// APB configuration registers: start address and break vector.
`timescale 1ns / 1ps
module bcx_cfg import bcx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_start_address,
    output logic [15:0] o_break_vector
);
    logic [15:0] r_start;
    logic [15:0] r_brk;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_brk   <= '0;
        end else if (w_wr) begin
            if (paddr[2] == REG_START) r_start <= pwdata[15:0];
            else r_brk <= pwdata[15:0];
        end
    end

    // read mux
    always_comb begin
        prdata = {16'h0, (paddr[2] == REG_START) ? r_start : r_brk};
    end

    assign o_start_address = r_start;
    assign o_break_vector  = r_brk;
endmodule

// File: rtl/bcx_exec.sv
// Single-pass instruction executor: architectural registers and write list.
`timescale 1ns / 1ps
module bcx_exec import bcx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_instr      i_instr,
    input  logic [15:0] i_start_address,
    input  logic [15:0] i_break_vector,
    output t_arch       o_arch,
    output logic [1:0]  o_nw,
    output logic [15:0] o_wa [3],
    output logic [7:0]  o_wd [3],
    output logic [1:0]  o_pen
);
    t_arch       r_arch;
    t_arch       n;
    logic [1:0]  nw;
    logic [15:0] wa [3];
    logic [7:0]  wd [3];
    logic [1:0]  pen;
    logic [8:0]  sum;
    logic [7:0]  m, addm, r, cmpreg;
    logic [8:0]  diff;
    logic        take, sh, isbr;
    logic [15:0] tgt, pcm1;
    logic [7:0]  s1, s2, s3, sp1, sp2;

    always_comb begin
        n      = r_arch;
        nw     = 2'd0;
        pen    = 2'd0;
        m      = i_instr.operand;
        s1     = i_instr.stack_bytes[7:0];
        s2     = i_instr.stack_bytes[15:8];
        s3     = i_instr.stack_bytes[23:16];
        sp1    = r_arch.sp - 8'd1;
        sp2    = r_arch.sp - 8'd2;
        pcm1   = r_arch.pc - 16'd1;
        for (int k = 0; k < 3; k++) begin
            wa[k] = '0;
            wd[k] = '0;
        end
        // adder shared by ADC and SBC
        addm = (i_instr.opcode == OP_SBC) ? ~m : m;
        sum  = {1'b0, r_arch.a} + {1'b0, addm} + {8'h0, r_arch.p[FL_C]};
        // compare
        case (i_instr.opcode)
            OP_CPX:  cmpreg = r_arch.x;
            OP_CPY:  cmpreg = r_arch.y;
            default: cmpreg = r_arch.a;
        endcase
        diff = {1'b0, cmpreg} - {1'b0, m};
        // shifter, with INC and DEC of the memory operand
        r  = i_instr.accumulator_mode ? r_arch.a : m;
        sh = 1'b0;
        case (i_instr.opcode)
            OP_ASL:  begin sh = r[7]; r = {r[6:0], 1'b0}; end
            OP_ROL:  begin sh = r[7]; r = {r[6:0], r_arch.p[FL_C]}; end
            OP_LSR:  begin sh = r[0]; r = {1'b0, r[7:1]}; end
            OP_ROR:  begin sh = r[0]; r = {r_arch.p[FL_C], r[7:1]}; end
            OP_DEC:  r = m - 8'd1;
            OP_INC:  r = m + 8'd1;
            default: ;
        endcase
        // branch condition and target
        isbr = 1'b1;
        case (i_instr.opcode)
            OP_BCC:  take = !r_arch.p[FL_C];
            OP_BCS:  take = r_arch.p[FL_C];
            OP_BEQ:  take = r_arch.p[FL_Z];
            OP_BNE:  take = !r_arch.p[FL_Z];
            OP_BMI:  take = r_arch.p[FL_N];
            OP_BPL:  take = !r_arch.p[FL_N];
            OP_BVC:  take = !r_arch.p[FL_V];
            OP_BVS:  take = r_arch.p[FL_V];
            default: begin take = 1'b0; isbr = 1'b0; end
        endcase
        tgt = r_arch.pc + {{8{m[7]}}, m};

        case (i_instr.opcode)
            OP_ADC, OP_SBC: begin
                n.a = sum[7:0];
                n.p[FL_C] = sum[8];
                n.p[FL_V] = (sum[7] ^ r_arch.a[7]) & (sum[7] ^ addm[7]);
                n.p[FL_Z] = (sum[7:0] == 8'h0);
                n.p[FL_N] = sum[7];
            end
            OP_AND, OP_EOR, OP_ORA, OP_LDA, OP_PLA, OP_TXA, OP_TYA: begin
                case (i_instr.opcode)
                    OP_AND:  n.a = r_arch.a & m;
                    OP_EOR:  n.a = r_arch.a ^ m;
                    OP_ORA:  n.a = r_arch.a | m;
                    OP_PLA:  begin n.a = s1; n.sp = r_arch.sp + 8'd1; end
                    OP_TXA:  n.a = r_arch.x;
                    OP_TYA:  n.a = r_arch.y;
                    default: n.a = m;
                endcase
                n.p[FL_Z] = (n.a == 8'h0);
                n.p[FL_N] = n.a[7];
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_DEC, OP_INC: begin
                if (i_instr.opcode != OP_DEC && i_instr.opcode != OP_INC)
                    n.p[FL_C] = sh;
                n.p[FL_Z] = (r == 8'h0);
                n.p[FL_N] = r[7];
                if (i_instr.accumulator_mode && i_instr.opcode != OP_DEC &&
                    i_instr.opcode != OP_INC) begin
                    n.a = r;
                end else begin
                    nw = 2'd1; wa[0] = i_instr.address; wd[0] = r;
                end
            end
            OP_BIT: begin
                n.p[FL_Z] = ((r_arch.a & m) == 8'h0);
                n.p[FL_V] = m[6];
                n.p[FL_N] = m[7];
            end
            OP_BRK: begin
                nw = 2'd3;
                wa[0] = {STACK_PAGE, r_arch.sp}; wd[0] = r_arch.pc[15:8];
                wa[1] = {STACK_PAGE, sp1};       wd[1] = r_arch.pc[7:0];
                wa[2] = {STACK_PAGE, sp2};       wd[2] = r_arch.p | PUSH_BITS;
                n.sp = r_arch.sp - 8'd3;
                n.p[FL_I] = 1'b1;
                n.pc = i_break_vector;
            end
            OP_CLC: n.p[FL_C] = 1'b0;
            OP_CLD: n.p[FL_D] = 1'b0;
            OP_CLI: n.p[FL_I] = 1'b0;
            OP_CLV: n.p[FL_V] = 1'b0;
            OP_SEC: n.p[FL_C] = 1'b1;
            OP_SED: n.p[FL_D] = 1'b1;
            OP_SEI: n.p[FL_I] = 1'b1;
            OP_CMP, OP_CPX, OP_CPY: begin
                n.p[FL_C] = !diff[8];
                n.p[FL_Z] = (diff[7:0] == 8'h0);
                n.p[FL_N] = diff[7];
            end
            OP_DEX, OP_INX, OP_LDX, OP_TAX, OP_TSX: begin
                case (i_instr.opcode)
                    OP_DEX:  n.x = r_arch.x - 8'd1;
                    OP_INX:  n.x = r_arch.x + 8'd1;
                    OP_TAX:  n.x = r_arch.a;
                    OP_TSX:  n.x = r_arch.sp;
                    default: n.x = m;
                endcase
                n.p[FL_Z] = (n.x == 8'h0);
                n.p[FL_N] = n.x[7];
            end
            OP_DEY, OP_INY, OP_LDY, OP_TAY: begin
                case (i_instr.opcode)
                    OP_DEY:  n.y = r_arch.y - 8'd1;
                    OP_INY:  n.y = r_arch.y + 8'd1;
                    OP_TAY:  n.y = r_arch.a;
                    default: n.y = m;
                endcase
                n.p[FL_Z] = (n.y == 8'h0);
                n.p[FL_N] = n.y[7];
            end
            OP_JMP: n.pc = i_instr.address;
            OP_JSR: begin
                nw = 2'd2;
                wa[0] = {STACK_PAGE, r_arch.sp}; wd[0] = pcm1[15:8];
                wa[1] = {STACK_PAGE, sp1};       wd[1] = pcm1[7:0];
                n.sp = sp2;
                n.pc = i_instr.address;
            end
            OP_PHA, OP_PHP: begin
                nw = 2'd1;
                wa[0] = {STACK_PAGE, r_arch.sp};
                wd[0] = (i_instr.opcode == OP_PHA) ? r_arch.a : (r_arch.p | PUSH_BITS);
                n.sp = sp1;
            end
            OP_PLP: begin
                n.sp = r_arch.sp + 8'd1;
                n.p  = (s1 & ~PUSH_BITS) | (r_arch.p & PUSH_BITS);
            end
            OP_RTI: begin
                n.sp = r_arch.sp + 8'd3;
                n.p  = (s1 & ~PUSH_BITS) | (r_arch.p & PUSH_BITS);
                n.pc = {s3, s2};
            end
            OP_RTS: begin
                n.sp = r_arch.sp + 8'd2;
                n.pc = {s2, s1} + 16'd1;
            end
            OP_STA, OP_STX, OP_STY: begin
                nw = 2'd1;
                wa[0] = i_instr.address;
                case (i_instr.opcode)
                    OP_STX:  wd[0] = r_arch.x;
                    OP_STY:  wd[0] = r_arch.y;
                    default: wd[0] = r_arch.a;
                endcase
            end
            OP_TXS: n.sp = r_arch.x;
            default: begin
                if (isbr && take) begin
                    n.pc = tgt;
                    pen  = (tgt[15:8] != r_arch.pc[15:8]) ? 2'd2 : 2'd1;
                end
            end
        endcase
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch.a  <= '0;
            r_arch.x  <= '0;
            r_arch.y  <= '0;
            r_arch.sp <= SP_RESET;
            r_arch.p  <= STATUS_RESET;
            r_arch.pc <= i_start_address;
        end else if (i_fire) begin
            r_arch <= n;
        end
    end

    assign o_arch = n;
    assign o_nw   = nw;
    assign o_wa   = wa;
    assign o_wd   = wd;
    assign o_pen  = pen;
endmodule

// File: test/eight_bit_cpu_execute_stage_tb.sv
// Testbench for the execute stage: random and directed instructions checked against a predictor.
`timescale 1ns / 1ps
module eight_bit_cpu_execute_stage_tb;
    import bcx_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:2]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bcx_in_if  in_if ();
    bcx_out_if out_if ();

    eight_bit_cpu_execute_stage uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pending instructions and predicted results
    t_instr  instr_q[$];
    t_result result_q[$];

    // predictor copy of the architectural state and registers
    logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
    logic [15:0] cpu_pc;
    logic [15:0] cfg_start, cfg_brk;

    int  errors;
    int  cycles;
    int  send_idle;
    int  recv_idle;
    bit  send_hold;
    bit  in_taken;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void set_nz(logic [7:0] v);
        cpu_p[FL_Z] = (v == 8'h00);
        cpu_p[FL_N] = v[7];
    endfunction

    function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
        logic [7:0] diff;
        diff = r - m;
        cpu_p[FL_C] = (r >= m);
        cpu_p[FL_Z] = (r == m);
        cpu_p[FL_N] = diff[7];
    endfunction

    function automatic void add_to_acc(logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, cpu_a} + {1'b0, m} + {8'h00, cpu_p[FL_C]};
        cpu_p[FL_C] = sum[8];
        cpu_p[FL_V] = (sum[7] ^ cpu_a[7]) & (sum[7] ^ m[7]);
        cpu_a = sum[7:0];
        set_nz(cpu_a);
    endfunction

    function automatic logic [1:0] take_branch(bit take, logic [7:0] off);
        logic [15:0] old_pc;
        if (!take) return 2'd0;
        old_pc = cpu_pc;
        cpu_pc = old_pc + {{8{off[7]}}, off};
        return (cpu_pc[15:8] != old_pc[15:8]) ? 2'd2 : 2'd1;
    endfunction

    // run one instruction on the predictor and queue the results it gives
    task automatic execute_instr(t_instr it);
        logic [15:0] wa[3];
        logic [7:0]  wd[3];
        int          nw, cnt;
        logic [1:0]  pen;
        logic [7:0]  r, m, s1, s2, s3;
        bit          cin;
        t_result     res;
        nw = 0;
        pen = 2'd0;
        m = it.operand;
        s1 = it.stack_bytes[7:0];
        s2 = it.stack_bytes[15:8];
        s3 = it.stack_bytes[23:16];
        case (it.opcode)
            OP_ADC: add_to_acc(m);
            OP_SBC: add_to_acc(~m);
            OP_AND: begin cpu_a = cpu_a & m; set_nz(cpu_a); end
            OP_EOR: begin cpu_a = cpu_a ^ m; set_nz(cpu_a); end
            OP_ORA: begin cpu_a = cpu_a | m; set_nz(cpu_a); end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                r = it.accumulator_mode ? cpu_a : m;
                cin = cpu_p[FL_C];
                if (it.opcode == OP_ASL || it.opcode == OP_ROL) begin
                    cpu_p[FL_C] = r[7];
                    r = {r[6:0], (it.opcode == OP_ROL) ? cin : 1'b0};
                end else begin
                    cpu_p[FL_C] = r[0];
                    r = {(it.opcode == OP_ROR) ? cin : 1'b0, r[7:1]};
                end
                set_nz(r);
                if (it.accumulator_mode) begin
                    cpu_a = r;
                end else begin
                    wa[0] = it.address; wd[0] = r; nw = 1;
                end
            end
            OP_BCC: pen = take_branch(!cpu_p[FL_C], m);
            OP_BCS: pen = take_branch(cpu_p[FL_C], m);
            OP_BEQ: pen = take_branch(cpu_p[FL_Z], m);
            OP_BMI: pen = take_branch(cpu_p[FL_N], m);
            OP_BNE: pen = take_branch(!cpu_p[FL_Z], m);
            OP_BPL: pen = take_branch(!cpu_p[FL_N], m);
            OP_BVC: pen = take_branch(!cpu_p[FL_V], m);
            OP_BVS: pen = take_branch(cpu_p[FL_V], m);
            OP_BIT: begin
                cpu_p[FL_Z] = ((cpu_a & m) == 8'h00);
                cpu_p[FL_V] = m[6];
                cpu_p[FL_N] = m[7];
            end
            OP_BRK: begin
                wa[0] = {STACK_PAGE, cpu_sp}; wd[0] = cpu_pc[15:8]; cpu_sp--;
                wa[1] = {STACK_PAGE, cpu_sp}; wd[1] = cpu_pc[7:0];  cpu_sp--;
                wa[2] = {STACK_PAGE, cpu_sp}; wd[2] = cpu_p | PUSH_BITS; cpu_sp--;
                nw = 3;
                cpu_p[FL_I] = 1'b1;
                cpu_pc = cfg_brk;
            end
            OP_CLC: cpu_p[FL_C] = 1'b0;
            OP_CLD: cpu_p[FL_D] = 1'b0;
            OP_CLI: cpu_p[FL_I] = 1'b0;
            OP_CLV: cpu_p[FL_V] = 1'b0;
            OP_SEC: cpu_p[FL_C] = 1'b1;
            OP_SED: cpu_p[FL_D] = 1'b1;
            OP_SEI: cpu_p[FL_I] = 1'b1;
            OP_CMP: compare_reg(cpu_a, m);
            OP_CPX: compare_reg(cpu_x, m);
            OP_CPY: compare_reg(cpu_y, m);
            OP_DEC, OP_INC: begin
                r = (it.opcode == OP_DEC) ? m - 8'd1 : m + 8'd1;
                set_nz(r);
                wa[0] = it.address; wd[0] = r; nw = 1;
            end
            OP_DEX: begin cpu_x--; set_nz(cpu_x); end
            OP_DEY: begin cpu_y--; set_nz(cpu_y); end
            OP_INX: begin cpu_x++; set_nz(cpu_x); end
            OP_INY: begin cpu_y++; set_nz(cpu_y); end
            OP_JMP: cpu_pc = it.address;
            OP_JSR: begin
                cpu_pc--;
                wa[0] = {STACK_PAGE, cpu_sp}; wd[0] = cpu_pc[15:8]; cpu_sp--;
                wa[1] = {STACK_PAGE, cpu_sp}; wd[1] = cpu_pc[7:0];  cpu_sp--;
                nw = 2;
                cpu_pc = it.address;
            end
            OP_LDA: begin cpu_a = m; set_nz(cpu_a); end
            OP_LDX: begin cpu_x = m; set_nz(cpu_x); end
            OP_LDY: begin cpu_y = m; set_nz(cpu_y); end
            OP_PHA: begin
                wa[0] = {STACK_PAGE, cpu_sp}; wd[0] = cpu_a; cpu_sp--; nw = 1;
            end
            OP_PHP: begin
                wa[0] = {STACK_PAGE, cpu_sp}; wd[0] = cpu_p | PUSH_BITS; cpu_sp--; nw = 1;
            end
            OP_PLA: begin cpu_sp++; cpu_a = s1; set_nz(cpu_a); end
            OP_PLP: begin
                cpu_sp++;
                cpu_p = (s1 & ~PUSH_BITS) | (cpu_p & PUSH_BITS);
            end
            OP_RTI: begin
                cpu_sp = cpu_sp + 8'd3;
                cpu_p = (s1 & ~PUSH_BITS) | (cpu_p & PUSH_BITS);
                cpu_pc = {s3, s2};
            end
            OP_RTS: begin
                cpu_sp = cpu_sp + 8'd2;
                cpu_pc = {s2, s1} + 16'd1;
            end
            OP_STA: begin wa[0] = it.address; wd[0] = cpu_a; nw = 1; end
            OP_STX: begin wa[0] = it.address; wd[0] = cpu_x; nw = 1; end
            OP_STY: begin wa[0] = it.address; wd[0] = cpu_y; nw = 1; end
            OP_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
            OP_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
            OP_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
            OP_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
            OP_TXS: cpu_sp = cpu_x;
            OP_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
            default: ;  // NOP and unused codes
        endcase
        cnt = (nw == 0) ? 1 : nw;
        for (int k = 0; k < cnt; k++) begin
            res.has_write       = (k < nw);
            res.write_address   = (k < nw) ? wa[k] : 16'h0000;
            res.write_data      = (k < nw) ? wd[k] : 8'h00;
            res.last            = (k + 1 == cnt);
            res.acc             = cpu_a;
            res.index_x         = cpu_x;
            res.index_y         = cpu_y;
            res.stack_pointer   = cpu_sp;
            res.flags           = cpu_p;
            res.program_counter = cpu_pc;
            res.branch_penalty  = pen;
            result_q.push_back(res);
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            errors++;
        end
    endtask

    // input acceptance, prediction, output check and cycle limit
    always @(posedge i_clk) begin
        t_result want, got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("eight_bit_cpu_execute_stage test failed");
            $finish;
        end else begin
            if (i_rst_n && in_if.valid && in_if.ready) begin
                execute_instr(in_if.data);
                in_taken = 1'b1;
            end
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (result_q.size() == 0) begin
                    $error("result item with nothing predicted");
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    check_field("has_write", want.has_write, got.has_write);
                    check_field("write_address", want.write_address, got.write_address);
                    check_field("write_data", want.write_data, got.write_data);
                    check_field("last", want.last, got.last);
                    check_field("acc", want.acc, got.acc);
                    check_field("index_x", want.index_x, got.index_x);
                    check_field("index_y", want.index_y, got.index_y);
                    check_field("stack_pointer", want.stack_pointer, got.stack_pointer);
                    check_field("flags", want.flags, got.flags);
                    check_field("program_counter", want.program_counter,
                                got.program_counter);
                    check_field("branch_penalty", want.branch_penalty, got.branch_penalty);
                end
            end
        end
    end

    // instruction driver and result backpressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_if.valid || in_taken) begin
                if (instr_q.size() != 0 && !send_hold &&
                    $urandom_range(99) >= send_idle) begin
                    in_if.data  <= instr_q.pop_front();
                    in_if.valid <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            in_taken = 1'b0;
            out_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic push_instr(t_op op, bit accm, logic [7:0] m, logic [15:0] addr,
                              logic [23:0] stk);
        t_instr it;
        it.opcode = op;
        it.accumulator_mode = accm;
        it.operand = m;
        it.address = addr;
        it.stack_bytes = stk;
        instr_q.push_back(it);
    endtask

    task automatic push_random(int count);
        t_instr it;
        repeat (count) begin
            it.opcode = 6'($urandom_range(63));
            it.accumulator_mode = 1'($urandom_range(1));
            it.operand = 8'($urandom_range(255));
            it.address = 16'($urandom_range(65535));
            it.stack_bytes = 24'($urandom_range(24'hFFFFFF));
            instr_q.push_back(it);
        end
    endtask

    task automatic wait_idle();
        while (instr_q.size() != 0 || in_if.valid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // register write: setup phase, then access phase
    task automatic reg_write(logic [0:0] idx, logic [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= idx; pwdata <= {16'h0000, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_START) cfg_start = value;
        else cfg_brk = value;
    endtask

    // reset, directed items, then three random phases
    initial begin
        errors = 0; cycles = 0;
        send_idle = 0; recv_idle = 0; send_hold = 1'b0; in_taken = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_if.valid = 1'b0; in_if.data = '0; out_if.ready = 1'b0;
        cpu_a = 8'h00; cpu_x = 8'h00; cpu_y = 8'h00;
        cpu_sp = SP_RESET; cpu_p = STATUS_RESET;
        cfg_start = 16'h0000; cfg_brk = 16'h0000; cpu_pc = 16'h0000;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        reg_write(REG_START, 16'hFFFF);
        reg_write(REG_BRK, 16'h0000);
        send_idle = 17; recv_idle = 82;
        // extremes: overflow, carry, page-crossing branches, stack ops
        push_instr(OP_LDA, 0, 8'h7F, 16'h0000, 24'h0);
        push_instr(OP_ADC, 0, 8'h01, 16'h0000, 24'h0);
        push_instr(OP_ADC, 0, 8'hFF, 16'hFFFF, 24'h0);
        push_instr(OP_SBC, 0, 8'h80, 16'h0000, 24'h0);
        push_instr(OP_SED, 0, 8'h00, 16'h0000, 24'h0);
        push_instr(OP_ADC, 0, 8'h09, 16'h0000, 24'h0);
        push_instr(OP_ASL, 1, 8'h00, 16'h0000, 24'h0);
        push_instr(OP_ROR, 0, 8'h01, 16'h1234, 24'h0);
        push_instr(OP_INC, 1, 8'hFF, 16'hFFFF, 24'h0);
        push_instr(OP_DEC, 0, 8'h00, 16'h0000, 24'h0);
        push_instr(OP_BIT, 0, 8'hC0, 16'h0000, 24'h0);
        push_instr(OP_BNE, 0, 8'h80, 16'h0000, 24'h0);
        push_instr(OP_BMI, 0, 8'h7F, 16'h0000, 24'h0);
        push_instr(OP_JMP, 0, 8'h00, 16'h00F0, 24'h0);
        push_instr(OP_BVS, 0, 8'h20, 16'h0000, 24'h0);
        push_instr(OP_BRK, 0, 8'h00, 16'h0000, 24'h0);
        push_instr(OP_PHP, 0, 8'h00, 16'h0000, 24'h0);
        push_instr(OP_PLP, 0, 8'h00, 16'h0000, 24'hFFFFFF);
        push_instr(OP_JSR, 0, 8'h00, 16'h0000, 24'h0);
        push_instr(OP_RTS, 0, 8'h00, 16'h0000, 24'hFFFFFF);
        push_instr(OP_RTI, 0, 8'h00, 16'h0000, 24'h00FF00);
        push_instr(OP_LDX, 0, 8'h00, 16'h0000, 24'h0);
        push_instr(OP_TXS, 0, 8'h00, 16'h0000, 24'h0);
        push_instr(OP_PLA, 0, 8'h00, 16'h0000, 24'h000080);
        push_instr(t_op'(6'd63), 0, 8'hFF, 16'hFFFF, 24'hFFFFFF);
        push_random(80);
        wait_idle();

        reg_write(REG_BRK, 16'hFFFF);
        reg_write(REG_START, 16'h0000);
        send_idle = 82; recv_idle = 17;
        push_random(80);
        wait_idle();

        reg_write(REG_BRK, 16'($urandom_range(65535)));
        reg_write(REG_START, 16'($urandom_range(65535)));
        send_idle = 0; recv_idle = 0;
        push_random(40);
        while (instr_q.size() != 0) @(posedge i_clk);
        // hold the sender until the block has drained everything
        send_hold = 1'b1;
        while (result_q.size() != 0 || in_if.valid) @(posedge i_clk);
        send_hold = 1'b0;
        push_random(40);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && result_q.size() == 0) begin
            $display("eight_bit_cpu_execute_stage test passed");
        end else begin
            $display("eight_bit_cpu_execute_stage test failed");
        end
        $finish;
    end

endmodule
